@@ rtl/core/alpm_pkg.sv @@
// Shared types, constants and pattern tables for the activity LED peak meter.
// Used by every module in rtl/core; depends on nothing else.
package alpm_pkg;

    localparam int NUM_LEVELS         = 6;
    localparam int NUM_THRESH         = NUM_LEVELS - 1;
    localparam int RATE_FRAC_BITS_DEF = 16;
    localparam int WHOLE_W            = 22;
    localparam int COEF_W             = 16;
    localparam int BYTES_W            = 16;
    localparam int RATE_SCALE         = 60;
    localparam int PAT_STEPS          = 32;
    localparam int CMD_DEPTH          = 2;

    localparam logic [4:0] PAT_LAST = 5'(PAT_STEPS - 1);
    localparam logic [2:0] LVL_NONE = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_THRESH_1   = 3'd0;
    localparam logic [2:0] REG_THRESH_2   = 3'd1;
    localparam logic [2:0] REG_THRESH_3   = 3'd2;
    localparam logic [2:0] REG_THRESH_4   = 3'd3;
    localparam logic [2:0] REG_THRESH_5   = 3'd4;
    localparam logic [2:0] REG_REFRESH    = 3'd5;
    localparam logic [2:0] REG_ATTACK     = 3'd6;
    localparam logic [2:0] REG_DECAY      = 3'd7;

    localparam logic [WHOLE_W-1:0] THRESH_RST [NUM_THRESH] =
        '{22'd256, 22'd2048, 22'd8192, 22'd24576, 22'd40960};
    localparam logic [7:0]        REFRESH_RST = 8'd120;
    localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd32768;
    localparam logic [COEF_W-1:0] DECAY_RST   = 16'd1966;

    // fixed output codes
    localparam logic [7:0] DARK_DELAY  = 8'd16;
    localparam logic [7:0] DARK_PAUSE  = 8'd255;
    localparam logic [7:0] LIT_SMOOTH  = 8'd16;
    localparam logic [7:0] LIT_PAUSE   = 8'd0;

    // per-level tables
    localparam int LVL_RED   [NUM_LEVELS] = '{0, 0, 160, 255, 255, 255};
    localparam int LVL_GREEN [NUM_LEVELS] = '{255, 255, 255, 190, 90, 0};
    localparam int LVL_BLUE  [NUM_LEVELS] = '{40, 0, 0, 0, 0, 0};
    localparam int LVL_PEAK  [NUM_LEVELS] = '{70, 130, 180, 220, 240, 255};
    // steps per pulse (32 / pulse count) and its (steps-1)^2
    localparam int LVL_STEPS [NUM_LEVELS] = '{32, 32, 16, 16, 8, 8};
    localparam int LVL_NSQ   [NUM_LEVELS] = '{961, 961, 225, 225, 49, 49};
    localparam logic [7:0] LVL_DELAY [NUM_LEVELS] =
        '{8'd4, 8'd3, 8'd2, 8'd2, 8'd1, 8'd1};

    typedef logic [NUM_LEVELS-1:0][PAT_STEPS-1:0][23:0] t_pat_lut;

    typedef struct packed {
        logic [NUM_THRESH-1:0][WHOLE_W-1:0] thr;
        logic [7:0]                         refresh_period;
        logic [COEF_W-1:0]                  attack_coef;
        logic [COEF_W-1:0]                  decay_coef;
    } t_cfg;

    typedef struct packed {
        logic       dark;
        logic [2:0] level;
    } t_cmd;

    // one pattern entry, laid out as the output tdata (last field lowest)
    typedef struct packed {
        logic [2:0] meter_level;
        logic [7:0] loop_pause;
        logic [7:0] smooth_amount;
        logic [7:0] step_delay;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [4:0] step_index;
    } t_step;

    // Colour table {blue, green, red} per level and step: instant attack,
    // quadratic decay over each pulse, scaled by the level's peak.
    function automatic t_pat_lut f_pat_lut();
        t_pat_lut lut;
        int mask;
        int r;
        int e;
        int env;
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            for (int i = 0; i < PAT_STEPS; i++) begin
                mask = LVL_STEPS[lv] - 1;
                r    = mask - (i & mask);
                e    = 25 + (230 * r * r) / LVL_NSQ[lv];
                env  = e * LVL_PEAK[lv] / 255;
                lut[lv][i] = {8'(LVL_BLUE[lv] * env / 255),
                              8'(LVL_GREEN[lv] * env / 255),
                              8'(LVL_RED[lv] * env / 255)};
            end
        end
        return lut;
    endfunction

    localparam t_pat_lut PAT_LUT = f_pat_lut();

endpackage

@@ rtl/core/activity_led_peak_meter.sv @@
// Top level of the activity LED peak meter: configuration registers and the
// front end / command queue / pattern generator chain. Depends on alpm_pkg,
// alpm_front, alpm_queue and alpm_back.
//
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tdata: frame_bytes; tuser: link_up
//  m_axis    | out       | tdata: pattern entry fields; tuser: dark; tlast: last
//  i_cfg_*   | in        | register index and data, written on i_cfg_we
//
// Flow: a connected frame passes the front end's setup state, the shift-add
// rate multiplier, update, sort and, if it emits, queue push; a disconnect
// goes from setup to queue push or straight back to idle. A pattern leaves at
// one entry per cycle as long as m_axis_tready stays high.
// Reset is synchronous and active low: rate estimate zero, no level shown,
// refresh counter zero, queue and output slot empty, registers at defaults.
// Stalls: output backpressure holds the generator; the two-entry command
// queue lets the front end keep taking frames until it fills.
module activity_led_peak_meter
    import alpm_pkg::*;
#(
    parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [WHOLE_W-1:0] i_cfg_wdata,
    // frame ticks
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // [15:0] frame_bytes
    input  logic               s_axis_tuser,   // [0] link_up
    // pattern entries
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [4:0] step_index, [12:5] red, [20:13] green, [28:21] blue,
    // [36:29] step_delay, [44:37] smooth_amount, [52:45] loop_pause,
    // [55:53] meter_level
    output logic [55:0]        m_axis_tdata,
    output logic               m_axis_tuser,   // [0] dark
    output logic               m_axis_tlast    // last entry of the pattern
);

    t_cfg  r_cfg;

    logic  w_push;
    t_cmd  w_push_cmd;
    logic  w_full;
    logic  w_pop;
    t_cmd  w_pop_cmd;
    logic  w_empty;
    t_step w_step;

    // Config registers, write only; user must write while idle, not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_THRESH; k++) begin
                r_cfg.thr[k] <= THRESH_RST[k];
            end
            r_cfg.refresh_period <= REFRESH_RST;
            r_cfg.attack_coef    <= ATTACK_RST;
            r_cfg.decay_coef     <= DECAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_THRESH_1: r_cfg.thr[0]         <= i_cfg_wdata;
                REG_THRESH_2: r_cfg.thr[1]         <= i_cfg_wdata;
                REG_THRESH_3: r_cfg.thr[2]         <= i_cfg_wdata;
                REG_THRESH_4: r_cfg.thr[3]         <= i_cfg_wdata;
                REG_THRESH_5: r_cfg.thr[4]         <= i_cfg_wdata;
                REG_REFRESH:  r_cfg.refresh_period <= i_cfg_wdata[7:0];
                REG_ATTACK:   r_cfg.attack_coef    <= i_cfg_wdata[COEF_W-1:0];
                REG_DECAY:    r_cfg.decay_coef     <= i_cfg_wdata[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: rate tracking, level sort, emit decision.
    alpm_front #(
        .RATE_FRAC_BITS(RATE_FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_link_up    (s_axis_tuser),
        .i_frame_bytes(s_axis_tdata),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd),
        .i_full       (w_full)
    );

    // Pattern commands waiting for the generator.
    alpm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_cmd  (w_pop_cmd),
        .o_empty(w_empty)
    );

    // Back end: one transfer per pattern step.
    alpm_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(w_empty),
        .i_cmd  (w_pop_cmd),
        .o_pop  (w_pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_step (w_step),
        .o_dark (m_axis_tuser),
        .o_last (m_axis_tlast)
    );

    // the entry struct already follows the tdata layout, lowest field last
    assign m_axis_tdata = w_step;

endmodule

@@ rtl/core/alpm_front.sv @@
// Front end: accepts frame ticks, tracks the rate estimate, sorts it into a
// level and decides on emission. Depends on alpm_pkg.
module alpm_front
    import alpm_pkg::*;
#(
    parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_link_up,
    input  logic [BYTES_W-1:0] i_frame_bytes,
    output logic               o_push,
    output t_cmd               o_cmd,
    input  logic               i_full
);

    localparam int EstW = WHOLE_W + RATE_FRAC_BITS;
    localparam int AccW = EstW + COEF_W;
    localparam int BitW = $clog2(COEF_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_SORT = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    logic [2:0]         r_state;
    logic               r_link;
    logic [BYTES_W-1:0] r_bytes;
    logic [EstW-1:0]    r_est;
    logic [EstW-1:0]    r_diff;
    logic [COEF_W-1:0]  r_coef;
    logic               r_rise;
    logic [AccW-1:0]    r_acc;
    logic [BitW-1:0]    r_bit;
    logic [2:0]         r_shown;
    logic [7:0]         r_refresh;
    t_cmd               r_cmd;

    logic [WHOLE_W-1:0] w_scaled;
    logic [EstW-1:0]    w_inst;
    logic [AccW-1:0]    n_acc;
    logic [EstW-1:0]    w_delta;
    logic [WHOLE_W-1:0] w_whole;
    logic [2:0]         w_level;

    assign w_scaled = WHOLE_W'(r_bytes) * WHOLE_W'(RATE_SCALE);
    assign w_inst   = {w_scaled, {RATE_FRAC_BITS{1'b0}}};
    // shift-add multiply, coefficient MSB first
    assign n_acc    = {r_acc[AccW-2:0], 1'b0} + (r_coef[r_bit] ? AccW'(r_diff) : '0);
    assign w_delta  = r_acc[AccW-1:COEF_W];
    assign w_whole  = r_est[RATE_FRAC_BITS +: WHOLE_W];

    // level = index of the first threshold not reached
    always_comb begin
        w_level = 3'(NUM_THRESH);
        for (int k = NUM_THRESH - 1; k >= 0; k--) begin
            if (w_whole < i_cfg.thr[k]) begin
                w_level = 3'(k);
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_push     = (r_state == S_PUSH) && !i_full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_est     <= '0;
            r_shown   <= LVL_NONE;
            r_refresh <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_link  <= i_link_up;
                        r_bytes <= i_frame_bytes;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (!r_link) begin
                        r_est <= '0;
                        if (r_shown != LVL_NONE) begin
                            r_shown <= LVL_NONE;
                            r_cmd   <= '{dark: 1'b1, level: 3'd0};
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (w_inst > r_est) begin
                            r_rise <= 1'b1;
                            r_diff <= w_inst - r_est;
                            r_coef <= i_cfg.attack_coef;
                        end else begin
                            r_rise <= 1'b0;
                            r_diff <= r_est - w_inst;
                            r_coef <= i_cfg.decay_coef;
                        end
                        r_acc   <= '0;
                        r_bit   <= BitW'(COEF_W - 1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= n_acc;
                    if (r_bit == '0) begin
                        r_state <= S_UPD;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_UPD: begin
                    r_est   <= r_rise ? r_est + w_delta : r_est - w_delta;
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    if (w_level != r_shown || r_refresh <= 8'd1) begin
                        r_shown   <= w_level;
                        r_refresh <= i_cfg.refresh_period;
                        r_cmd     <= '{dark: 1'b0, level: w_level};
                        r_state   <= S_PUSH;
                    end else begin
                        r_refresh <= r_refresh - 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/alpm_queue.sv @@
// Short command queue between the front end and the pattern generator.
// Depends on alpm_pkg.
module alpm_queue
    import alpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PtrW = $clog2(CMD_DEPTH);
    localparam int CntW = $clog2(CMD_DEPTH + 1);

    t_cmd            r_mem [CMD_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntW'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(CMD_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(CMD_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/alpm_back.sv @@
// Pattern generator: plays one queued command as 32 pattern entries into a
// registered output slot. Depends on alpm_pkg (PAT_LUT and level tables).
module alpm_back
    import alpm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_empty,
    input  t_cmd  i_cmd,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_step o_step,
    output logic  o_dark,
    output logic  o_last
);

    logic       r_busy;
    logic [4:0] r_step;
    t_cmd       r_cmd;
    logic       r_valid;
    t_step      r_out;
    logic       r_dark;
    logic       r_last;

    logic       w_load;
    logic [23:0] w_rgb;
    t_step      w_next;

    assign w_rgb = PAT_LUT[r_cmd.level][r_step];

    always_comb begin
        w_next.step_index = r_step;
        if (r_cmd.dark) begin
            w_next.red           = '0;
            w_next.green         = '0;
            w_next.blue          = '0;
            w_next.step_delay    = DARK_DELAY;
            w_next.smooth_amount = '0;
            w_next.loop_pause    = DARK_PAUSE;
            w_next.meter_level   = '0;
        end else begin
            w_next.red           = w_rgb[7:0];
            w_next.green         = w_rgb[15:8];
            w_next.blue          = w_rgb[23:16];
            w_next.step_delay    = LVL_DELAY[r_cmd.level];
            w_next.smooth_amount = LIT_SMOOTH;
            w_next.loop_pause    = LIT_PAUSE;
            w_next.meter_level   = r_cmd.level;
        end
    end

    // advance one step whenever the output slot is free or being drained
    assign w_load = r_busy && (!r_valid || i_ready);
    assign o_pop  = !r_busy && !i_empty;

    assign o_valid = r_valid;
    assign o_step  = r_out;
    assign o_dark  = r_dark;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_load) begin
            r_out  <= w_next;
            r_dark <= r_cmd.dark;
            r_last <= (r_step == PAT_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_load) begin
                r_step <= r_step + 1'b1;
                if (r_step == PAT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ verif/alpm_pattern_checker.sv @@
// Pattern checker for the activity LED peak meter: tracks register writes and
// frame transfers, predicts every pattern entry and compares the output stream.
// Depends on alpm_pkg for register indexes, reset values and output codes.
module alpm_pattern_checker
    import alpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [WHOLE_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [15:0]        i_in_data,     // [15:0] frame_bytes
    input  logic               i_in_user,     // [0] link_up
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [55:0]        i_out_data,    // t_step layout, step_index lowest
    input  logic               i_out_user,    // [0] dark
    input  logic               i_out_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_steps_checked,
    output int                 o_lit_patterns,
    output int                 o_dark_patterns
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC          = RATE_FRAC_BITS_DEF;
    localparam int SHOWN_REPORTS = 10;

    localparam int HUE_RED   [NUM_LEVELS] = '{0, 0, 160, 255, 255, 255};
    localparam int HUE_GREEN [NUM_LEVELS] = '{255, 255, 255, 190, 90, 0};
    localparam int HUE_BLUE  [NUM_LEVELS] = '{40, 0, 0, 0, 0, 0};
    localparam int PULSES    [NUM_LEVELS] = '{1, 1, 2, 2, 4, 4};
    localparam int PEAK      [NUM_LEVELS] = '{70, 130, 180, 220, 240, 255};
    localparam int DELAY     [NUM_LEVELS] = '{4, 3, 2, 2, 1, 1};

    typedef struct packed {
        logic [4:0] step_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] step_delay;
        logic [7:0] smooth_amount;
        logic [7:0] loop_pause;
        logic       dark;
        logic [2:0] meter_level;
        logic       last;
    } led_step_t;

    logic [WHOLE_W-1:0] thr [NUM_THRESH];
    logic [7:0]         refresh_period;
    logic [15:0]        attack_coef;
    logic [15:0]        decay_coef;

    logic [63:0]        rate_est;
    logic [2:0]         shown_level;
    logic [7:0]         refresh_left;

    led_step_t          steps_due [$];
    int                 fail_count    = 0;
    int                 pending       = 0;
    int                 steps_checked = 0;
    int                 lit_patterns  = 0;
    int                 dark_patterns = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending;
    assign o_steps_checked = steps_checked;
    assign o_lit_patterns  = lit_patterns;
    assign o_dark_patterns = dark_patterns;

    function automatic string fmt_step(led_step_t s);
        return $sformatf("step=%0d rgb=%0d/%0d/%0d delay=%0d smooth=%0d pause=%0d dark=%0b lvl=%0d last=%0b",
                         s.step_index, s.red, s.green, s.blue, s.step_delay,
                         s.smooth_amount, s.loop_pause, s.dark, s.meter_level, s.last);
    endfunction

    task automatic report_bad(input string what, input string detail);
        fail_count++;
        if (fail_count <= SHOWN_REPORTS)
            $display("[%0t] %s: %s", $realtime, what, detail);
    endtask

    // Push the 32 entries of one pattern: dark, or lit pulses with an instant
    // attack and a quadratic fall over each pulse.
    task automatic queue_pattern(input logic [2:0] lv, input logic is_dark);
        led_step_t s;
        int span;
        int n;
        int r;
        int e;
        int env;
        span = PAT_STEPS / PULSES[lv];
        n    = span - 1;
        for (int i = 0; i < PAT_STEPS; i++) begin
            s.step_index = 5'(i);
            s.dark       = is_dark;
            s.last       = (i == PAT_STEPS - 1);
            if (is_dark) begin
                s.red           = 8'd0;
                s.green         = 8'd0;
                s.blue          = 8'd0;
                s.step_delay    = DARK_DELAY;
                s.smooth_amount = 8'd0;
                s.loop_pause    = DARK_PAUSE;
                s.meter_level   = 3'd0;
            end else begin
                r   = n - (i % span);
                e   = 25 + (230 * r * r) / (n * n);
                env = e * PEAK[lv] / 255;
                s.red           = 8'(HUE_RED[lv] * env / 255);
                s.green         = 8'(HUE_GREEN[lv] * env / 255);
                s.blue          = 8'(HUE_BLUE[lv] * env / 255);
                s.step_delay    = 8'(DELAY[lv]);
                s.smooth_amount = LIT_SMOOTH;
                s.loop_pause    = LIT_PAUSE;
                s.meter_level   = lv;
            end
            steps_due.push_back(s);
        end
        if (is_dark)
            dark_patterns++;
        else
            lit_patterns++;
    endtask

    // One frame tick: disconnect, or rate update, level sort, emit or count down.
    task automatic predict_frame(input logic up, input logic [15:0] bytes);
        logic [63:0] target;
        logic [63:0] whole;
        logic [2:0]  lv;
        logic        fire;
        if (!up) begin
            rate_est = '0;
            if (shown_level != LVL_NONE) begin
                shown_level = LVL_NONE;
                queue_pattern(3'd0, 1'b1);
            end
        end else begin
            target = (64'(bytes) * 64'd60) << FRAC;
            if (target > rate_est)
                rate_est = rate_est + ((64'(attack_coef) * (target - rate_est)) >> 16);
            else
                rate_est = rate_est - ((64'(decay_coef) * (rate_est - target)) >> 16);
            whole = rate_est >> FRAC;
            lv    = 3'd0;
            while (lv < 3'(NUM_LEVELS - 1) && whole >= 64'(thr[lv]))
                lv++;
            fire = 1'b1;
            if (lv == shown_level && refresh_left > 8'd1) begin
                refresh_left = refresh_left - 8'd1;
                fire         = 1'b0;
            end
            if (fire) begin
                shown_level  = lv;
                refresh_left = refresh_period;
                queue_pattern(lv, 1'b0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_step     raw;
        led_step_t got;
        led_step_t want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_THRESH; k++)
                thr[k] = THRESH_RST[k];
            refresh_period = REFRESH_RST;
            attack_coef    = ATTACK_RST;
            decay_coef     = DECAY_RST;
            rate_est       = '0;
            shown_level    = LVL_NONE;
            refresh_left   = 8'd0;
            steps_due.delete();
            pending        = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_REFRESH: refresh_period = i_cfg_wdata[7:0];
                    REG_ATTACK:  attack_coef    = i_cfg_wdata[15:0];
                    REG_DECAY:   decay_coef     = i_cfg_wdata[15:0];
                    default:     thr[i_cfg_addr] = i_cfg_wdata;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_frame(i_in_user, i_in_data);
            if (i_out_valid && i_out_ready) begin
                raw               = t_step'(i_out_data);
                got.step_index    = raw.step_index;
                got.red           = raw.red;
                got.green         = raw.green;
                got.blue          = raw.blue;
                got.step_delay    = raw.step_delay;
                got.smooth_amount = raw.smooth_amount;
                got.loop_pause    = raw.loop_pause;
                got.dark          = i_out_user;
                got.meter_level   = raw.meter_level;
                got.last          = i_out_last;
                if (steps_due.size() == 0) begin
                    report_bad("entry with no pattern pending", fmt_step(got));
                end else begin
                    want = steps_due.pop_front();
                    steps_checked++;
                    if (got !== want)
                        report_bad("pattern entry mismatch",
                                   {"expected ", fmt_step(want), " got ", fmt_step(got)});
                end
            end
            pending = steps_due.size();
        end
    end

endmodule

@@ verif/tb_activity_led_peak_meter.sv @@
// Testbench top for the activity LED peak meter: clock, reset, register
// writes, frame stimulus and output backpressure, plus the final verdict.
// Depends on alpm_pkg, the block under test and alpm_pattern_checker.
module tb_activity_led_peak_meter
    import alpm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    // margin for the front end to finish a connected frame
    localparam int SETTLE_CYCLES  = 40;
    localparam int SQUEEZE_CYCLES = 500;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_FRAMES   = 24;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam logic [WHOLE_W-1:0] THR_MAX = '1;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [2:0]         i_cfg_addr    = REG_THRESH_1;
    logic [WHOLE_W-1:0] i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = '0;   // [15:0] frame_bytes
    logic               s_axis_tuser  = 1'b0; // [0] link_up
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [55:0]        m_axis_tdata;         // step_index lowest ... meter_level highest
    logic               m_axis_tuser;         // [0] dark
    logic               m_axis_tlast;

    int                 fail_count;
    int                 pending;
    int                 steps_checked;
    int                 lit_patterns;
    int                 dark_patterns;

    // Stimulus-side copy of the thresholds, used to aim frame sizes at them.
    logic [WHOLE_W-1:0] thr_now [NUM_THRESH];
    bit                 tx_steady      = 1'b0;
    bit                 rx_steady      = 1'b0;
    bit                 squeeze        = 1'b0;
    int                 frames_sent    = 0;
    int                 settings_count = 0;
    int                 cycle_count    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    activity_led_peak_meter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    alpm_pattern_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_in_user       (s_axis_tuser),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_out_user      (m_axis_tuser),
        .i_out_last      (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_steps_checked (steps_checked),
        .o_lit_patterns  (lit_patterns),
        .o_dark_patterns (dark_patterns)
    );

    // Watchdog: a hung handshake or a missing pattern ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pattern entries still due",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coefficients lean random but hit both ends now and then.
    function automatic logic [15:0] pick_coef();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'd0;
        else if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Offer one frame and hold it until the transfer. Valid stays high on
    // return so a following frame can go out back to back.
    task automatic send_frame(input logic up, input logic [15:0] bytes);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= up;
        s_axis_tdata  <= bytes;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        frames_sent++;
    endtask

    // Drop valid, wait out every pending entry, then give the front end time
    // to finish a frame that produced nothing.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all eight registers, one per cycle; thresholds come from thr_now.
    task automatic load_settings(input logic [7:0] refresh, input logic [15:0] attack,
                                 input logic [15:0] decay);
        i_cfg_we <= 1'b1;
        for (int k = 0; k < NUM_THRESH; k++) begin
            i_cfg_addr  <= REG_THRESH_1 + 3'(k);
            i_cfg_wdata <= thr_now[k];
            @(posedge i_clk);
        end
        i_cfg_addr  <= REG_REFRESH;
        i_cfg_wdata <= WHOLE_W'(refresh);
        @(posedge i_clk);
        i_cfg_addr  <= REG_ATTACK;
        i_cfg_wdata <= WHOLE_W'(attack);
        @(posedge i_clk);
        i_cfg_addr  <= REG_DECAY;
        i_cfg_wdata <= WHOLE_W'(decay);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Random settings, then a run of frames: mostly connected, sized small,
    // near a threshold, or anywhere in the 16-bit range.
    task automatic random_phase(input int count);
        int          mode;
        int          r;
        int          near;
        logic [21:0] acc;
        logic [7:0]  refresh;
        logic        up;
        logic [15:0] bytes;
        mode = $urandom_range(0, 9);
        acc  = 22'($urandom_range(0, 3000));
        for (int k = 0; k < NUM_THRESH; k++) begin
            if (mode < 6) begin
                thr_now[k] = acc;
                acc        = acc + 22'($urandom_range(0, 20000));
            end else if (mode < 8) begin
                thr_now[k] = 22'($urandom);
            end else begin
                thr_now[k] = 22'($urandom_range(0, 50));
            end
        end
        refresh = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        load_settings(refresh, pick_coef(), pick_coef());
        for (int f = 0; f < count; f++) begin
            if ($urandom_range(0, 19) == 0)
                tx_steady = !tx_steady;
            up = ($urandom_range(0, 99) >= 8);
            r  = $urandom_range(0, 99);
            if (r < 35) begin
                bytes = 16'($urandom_range(0, 900));
            end else if (r < 65) begin
                near  = int'(thr_now[$urandom_range(0, NUM_THRESH - 1)] / 60)
                        + $urandom_range(0, 40) - 20;
                bytes = (near < 0) ? 16'd0 : (near > 65535) ? 16'hFFFF : 16'(near);
            end else if (r < 90) begin
                bytes = 16'($urandom);
            end else begin
                bytes = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
            end
            send_frame(up, bytes);
        end
        settle();
    endtask

    // Output side: ready for random runs with random gaps. A squeeze request
    // from the stimulus holds ready low for a fixed long stretch.
    initial begin
        int run;
        int gap;
        @(posedge i_clk);
        forever begin
            if (squeeze) begin
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                squeeze = 1'b0;
            end
            m_axis_tready <= 1'b1;
            run = $urandom_range(1, 40);
            repeat (run) @(posedge i_clk);
            if ($urandom_range(0, 14) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        thr_now = THRESH_RST;

        // Default registers: climb through the levels, hold, then disconnect.
        send_frame(1'b0, 16'd0);        // nothing shown yet: disconnect is silent
        send_frame(1'b1, 16'd0);        // first connected frame shows level zero
        send_frame(1'b1, 16'd10);
        send_frame(1'b1, 16'd200);
        send_frame(1'b1, 16'd900);
        send_frame(1'b1, 16'hFFFF);
        send_frame(1'b1, 16'd0);        // slow decay keeps the level, no refresh yet
        send_frame(1'b0, 16'hFFFF);     // disconnect while lit: dark pattern
        send_frame(1'b0, 16'd0);        // already dark: nothing
        settle();

        // All thresholds zero, fastest refresh, full-weight coefficients.
        thr_now = '{22'd0, 22'd0, 22'd0, 22'd0, 22'd0};
        load_settings(8'd1, 16'hFFFF, 16'hFFFF);
        send_frame(1'b1, 16'd0);
        send_frame(1'b1, 16'd0);
        send_frame(1'b1, 16'hFFFF);
        send_frame(1'b0, 16'd0);
        settle();

        // Unreachable thresholds, zero refresh period re-emits every frame,
        // zero coefficients freeze the estimate.
        thr_now = '{THR_MAX, THR_MAX, THR_MAX, THR_MAX, THR_MAX};
        load_settings(8'd0, 16'd0, 16'd0);
        send_frame(1'b1, 16'hFFFF);
        send_frame(1'b1, 16'hFFFF);
        send_frame(1'b0, 16'd0);
        settle();

        // Thresholds out of order cap the level; longest refresh period.
        thr_now = '{22'd100, 22'd50, THR_MAX, 22'd0, 22'd0};
        load_settings(8'd255, 16'hFFFF, 16'd32768);
        send_frame(1'b1, 16'd3);
        send_frame(1'b1, 16'd1);
        send_frame(1'b1, 16'd0);
        settle();

        // Steady level with a short refresh: re-emit on every third frame.
        thr_now = THRESH_RST;
        load_settings(8'd3, ATTACK_RST, DECAY_RST);
        repeat (6) send_frame(1'b1, 16'd100);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(PHASE_FRAMES);

        // Backpressure: every frame emits while the receiver stalls, so the
        // command queue fills and the input must stall too.
        thr_now = THRESH_RST;
        load_settings(8'd1, ATTACK_RST, DECAY_RST);
        tx_steady = 1'b1;
        squeeze   = 1'b1;
        repeat (10) send_frame(1'b1, 16'($urandom_range(0, 2000)));
        settle();

        $display("Sent %0d frames under %0d register settings in %0d cycles.",
                 frames_sent, settings_count, cycle_count);
        $display("Checked %0d entries from %0d lit and %0d dark patterns.",
                 steps_checked, lit_patterns, dark_patterns);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ activity_led_peak_meter.f @@
rtl/core/alpm_pkg.sv
rtl/core/alpm_front.sv
rtl/core/alpm_queue.sv
rtl/core/alpm_back.sv
rtl/core/activity_led_peak_meter.sv
verif/alpm_pattern_checker.sv
verif/tb_activity_led_peak_meter.sv
